/* src/ti3_pkg.sv */
// Shared widths and payload types for the 3D triangle incenter pipeline.
package ti3_pkg;

  // Coordinate format is signed, CoordBits wide; the binary point does not enter the math.
  localparam int CoordBits = 32;
  localparam int DiffBits  = CoordBits + 1;
  localparam int SqBits    = 2 * DiffBits;
  localparam int SumBits   = SqBits + 2;
  localparam int LenBits   = CoordBits + 2;
  localparam int DenBits   = LenBits + 2;
  localparam int ProdBits  = LenBits + CoordBits;
  localparam int AccBits   = ProdBits + 3;
  // Start-to-done latency through diff, square, sum, root, product, accumulate, round, divide and output.
  localparam int Latency   = 7 + LenBits + CoordBits;

  typedef struct packed {
    logic signed [CoordBits-1:0] first_x;
    logic signed [CoordBits-1:0] first_y;
    logic signed [CoordBits-1:0] first_z;
    logic signed [CoordBits-1:0] second_x;
    logic signed [CoordBits-1:0] second_y;
    logic signed [CoordBits-1:0] second_z;
    logic signed [CoordBits-1:0] third_x;
    logic signed [CoordBits-1:0] third_y;
    logic signed [CoordBits-1:0] third_z;
  } tri_in_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] center_x;
    logic signed [CoordBits-1:0] center_y;
    logic signed [CoordBits-1:0] center_z;
    logic                        degenerate;
  } center_out_t;

endpackage

/* src/ti3_delay.sv */
// Fixed-length payload delay line, one register per stage.
module ti3_delay import ti3_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = 1
) (
  input  logic             clk,
  input  logic [Width-1:0] d,
  output logic [Width-1:0] q
);

  logic [Width-1:0] stg [Depth];

  // Advance every stage each cycle
  always_ff @(posedge clk) begin
    stg[0] <= d;
    for (int i = 1; i < Depth; i++) begin
      stg[i] <= stg[i-1];
    end
  end

  assign q = stg[Depth-1];

endmodule

/* src/ti3_sqrt.sv */
// Pipelined floor square root, one root bit resolved per stage.
module ti3_sqrt import ti3_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [SumBits-1:0] radicand,
  output logic               out_valid,
  output logic [LenBits-1:0] root
);

  localparam int TrialBits = SumBits + 1;

  logic [SumBits-1:0] rem [LenBits];
  logic [LenBits-1:0] quo [LenBits];
  logic               vld [LenBits];

  for (genvar k = 0; k < LenBits; k++) begin : g_stage
    localparam int B = LenBits - 1 - k;
    logic [SumBits-1:0]   r_in;
    logic [LenBits-1:0]   q_in;
    logic                 v_in;
    logic [TrialBits-1:0] trial;
    logic                 ge;

    if (k == 0) begin : g_first
      assign r_in = radicand;
      assign q_in = '0;
      assign v_in = in_valid;
    end else begin : g_next
      assign r_in = rem[k-1];
      assign q_in = quo[k-1];
      assign v_in = vld[k-1];
    end

    // Try setting bit B: (q + 2^B)^2 - q^2 = q*2^(B+1) + 2^(2B)
    always_comb begin
      trial = (TrialBits'(q_in) << (B + 1)) + (TrialBits'(1) << (2 * B));
      ge    = ({1'b0, r_in} >= trial);
    end

    // Advance remainder and partial root
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= v_in;
      end
      rem[k] <= ge ? (r_in - trial[SumBits-1:0]) : r_in;
      quo[k] <= ge ? (q_in | (LenBits'(1) << B)) : q_in;
    end
  end

  assign out_valid = vld[LenBits-1];
  assign root      = quo[LenBits-1];

endmodule

/* src/ti3_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module ti3_div import ti3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [AccBits-1:0]   num,
  input  logic [DenBits-1:0]   den,
  output logic                 out_valid,
  output logic [CoordBits-1:0] quot
);

  localparam int RemBits = DenBits + 1;

  logic [RemBits-1:0]   rem  [CoordBits];
  logic [AccBits-1:0]   numr [CoordBits];
  logic [DenBits-1:0]   dnm  [CoordBits];
  logic [CoordBits-1:0] quo  [CoordBits];
  logic                 vld  [CoordBits];

  for (genvar k = 0; k < CoordBits; k++) begin : g_stage
    localparam int B = CoordBits - 1 - k;
    logic [RemBits-1:0]   r_in;
    logic [AccBits-1:0]   n_in;
    logic [DenBits-1:0]   d_in;
    logic [CoordBits-1:0] q_in;
    logic                 v_in;
    logic [RemBits-1:0]   r2;
    logic                 ge;

    if (k == 0) begin : g_first
      // Upper numerator bits are already below the divisor
      assign r_in = num[AccBits-1:CoordBits];
      assign n_in = num;
      assign d_in = den;
      assign q_in = '0;
      assign v_in = in_valid;
    end else begin : g_next
      assign r_in = rem[k-1];
      assign n_in = numr[k-1];
      assign d_in = dnm[k-1];
      assign q_in = quo[k-1];
      assign v_in = vld[k-1];
    end

    // Shift in next numerator bit and compare
    always_comb begin
      r2 = {r_in[RemBits-2:0], n_in[B]};
      ge = (r2 >= {1'b0, d_in});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= v_in;
      end
      rem[k]  <= ge ? (r2 - {1'b0, d_in}) : r2;
      numr[k] <= n_in;
      dnm[k]  <= d_in;
      quo[k]  <= ge ? (q_in | (CoordBits'(1) << B)) : q_in;
    end
  end

  assign out_valid = vld[CoordBits-1];
  assign quot      = quo[CoordBits-1];

endmodule

/* src/triangle_incenter_3d.sv */
// Top level: incenter of a 3D triangle, fully pipelined.
//
//   channel   | ports                      | transfer
//   ----------+----------------------------+-------------------------------
//   triangle  | start, busy, operands      | start high and busy low at edge
//   incenter  | done, result               | done high for one cycle
//
// One triangle is taken every cycle; busy is always low.
// Each result passes through the pipeline, which has one stage per root bit in the square
// root units and one stage per quotient bit in the dividers.
// Reset clears the valid bits only; results are never held off downstream.
module triangle_incenter_3d import ti3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  tri_in_t     operands,
  output logic        done,
  output center_out_t result
);

  logic                       accept;
  logic signed [CoordBits-1:0] pt_in [3][3];
  logic signed [CoordBits-1:0] pt_d  [3][3];
  logic                       v1, v2, v3, v4, v5, v6;
  logic [DiffBits-1:0]        dm1  [3][3];
  logic [SqBits-1:0]          sq2  [3][3];
  logic [SumBits-1:0]         sum3 [3];
  tri_in_t                    vert1, vert_d;
  logic [LenBits-1:0]         len  [3];
  logic                       lv   [3];
  logic [ProdBits-1:0]        prod4 [3][3];
  logic                       sgn4  [3][3];
  logic [DenBits-1:0]         den4, den5, den6;
  logic signed [AccBits-1:0]  acc5 [3];
  logic [AccBits-1:0]         num6 [3];
  logic [2:0]                 neg6;
  logic                       deg6;
  logic [CoordBits-1:0]       quo  [3];
  logic                       dv   [3];
  logic [3:0]                 flg_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Unpack vertices, rows A B C, columns x y z
  always_comb begin
    pt_in[0][0] = operands.first_x;  pt_in[0][1] = operands.first_y;
    pt_in[0][2] = operands.first_z;  pt_in[1][0] = operands.second_x;
    pt_in[1][1] = operands.second_y; pt_in[1][2] = operands.second_z;
    pt_in[2][0] = operands.third_x;  pt_in[2][1] = operands.third_y;
    pt_in[2][2] = operands.third_z;
    pt_d[0][0]  = vert_d.first_x;    pt_d[0][1]  = vert_d.first_y;
    pt_d[0][2]  = vert_d.first_z;    pt_d[1][0]  = vert_d.second_x;
    pt_d[1][1]  = vert_d.second_y;   pt_d[1][2]  = vert_d.second_z;
    pt_d[2][0]  = vert_d.third_x;    pt_d[2][1]  = vert_d.third_y;
    pt_d[2][2]  = vert_d.third_z;
  end

  // Stage 1: side differences, side s is opposite vertex s
  always_ff @(posedge clk) begin
    logic signed [DiffBits-1:0] d;
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    vert1 <= operands;
    for (int s = 0; s < 3; s++) begin
      for (int k = 0; k < 3; k++) begin
        d = DiffBits'(pt_in[(s+1)%3][k]) - DiffBits'(pt_in[(s+2)%3][k]);
        dm1[s][k] <= d[DiffBits-1] ? DiffBits'(-d) : DiffBits'(d);
      end
    end
  end

  // Stage 2: squares; stage 3: squared lengths
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v2 <= v1;
      v3 <= v2;
    end
    for (int s = 0; s < 3; s++) begin
      for (int k = 0; k < 3; k++) begin
        sq2[s][k] <= dm1[s][k] * dm1[s][k];
      end
      sum3[s] <= SumBits'(sq2[s][0]) + SumBits'(sq2[s][1]) + SumBits'(sq2[s][2]);
    end
  end

  for (genvar s = 0; s < 3; s++) begin : g_len
    ti3_sqrt u_sqrt (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v3),
      .radicand  (sum3[s]),
      .out_valid (lv[s]),
      .root      (len[s])
    );
  end

  // Hold vertices until the side lengths arrive
  ti3_delay #(.Width($bits(tri_in_t)), .Depth(2 + LenBits)) u_vert_dly (
    .clk (clk),
    .d   (vert1),
    .q   (vert_d)
  );

  // Stage 4: weight magnitudes and perimeter
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= lv[0];
    end
    den4 <= DenBits'(len[0]) + DenBits'(len[1]) + DenBits'(len[2]);
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        sgn4[i][k]  <= pt_d[i][k][CoordBits-1];
        prod4[i][k] <= len[i] * (pt_d[i][k][CoordBits-1] ? CoordBits'(-pt_d[i][k])
                                                          : CoordBits'(pt_d[i][k]));
      end
    end
  end

  // Stage 5: signed weighted sums
  always_ff @(posedge clk) begin
    logic signed [AccBits-1:0] t;
    logic signed [AccBits-1:0] a;
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    den5 <= den4;
    for (int k = 0; k < 3; k++) begin
      a = '0;
      for (int i = 0; i < 3; i++) begin
        t = signed'(AccBits'(prod4[i][k]));
        a = a + (sgn4[i][k] ? -t : t);
      end
      acc5[k] <= a;
    end
  end

  // Stage 6: take magnitude and add half the perimeter for rounding
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    den6 <= den5;
    deg6 <= (den5 == '0);
    for (int k = 0; k < 3; k++) begin
      neg6[k] <= acc5[k][AccBits-1];
      num6[k] <= (acc5[k][AccBits-1] ? AccBits'(-acc5[k]) : AccBits'(acc5[k]))
                 + AccBits'(den5 >> 1);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    ti3_div u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v6),
      .num       (num6[k]),
      .den       (den6),
      .out_valid (dv[k]),
      .quot      (quo[k])
    );
  end

  // Carry sign and degenerate flags across the divider
  ti3_delay #(.Width(4), .Depth(CoordBits)) u_flag_dly (
    .clk (clk),
    .d   ({deg6, neg6}),
    .q   (flg_d)
  );

  // Output register: restore sign, drop to zero when degenerate
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[0];
    end
    result.degenerate <= flg_d[3];
    result.center_x   <= flg_d[3] ? '0 : (flg_d[0] ? -quo[0] : quo[0]);
    result.center_y   <= flg_d[3] ? '0 : (flg_d[1] ? -quo[1] : quo[1]);
    result.center_z   <= flg_d[3] ? '0 : (flg_d[2] ? -quo[2] : quo[2]);
  end

  // Every transfer is followed by done once Latency has elapsed
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##Latency done)
    else $error("result missing after fixed latency");

  // Divider lanes stay in lockstep
  a_lanes: assert property (@(posedge clk) disable iff (rst)
    (dv[0] == dv[1]) && (dv[1] == dv[2]))
    else $error("divider lanes out of step");

  // A degenerate triangle reports the origin
  a_degenerate: assert property (@(posedge clk) disable iff (rst)
    done && result.degenerate |->
      (result.center_x == '0) && (result.center_y == '0) && (result.center_z == '0))
    else $error("degenerate result not zero");

endmodule

/* sim/tb_triangle_incenter_3d.sv */
// Testbench for the 3D triangle incenter pipeline: directed table, random triangles, scoreboard.
`timescale 1ns / 100ps

module tb_triangle_incenter_3d;
  import ti3_pkg::*;

  localparam int NumRandom = 2000;
  localparam int CycleLimit = 200000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  tri_in_t     operands;
  logic        done;
  center_out_t result;

  triangle_incenter_3d dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operands(operands),
    .done(done),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  center_out_t incenter_q[$];
  int          mismatches;
  int          cycles;
  int          results_seen;
  int          degenerate_seen;

  // Floor square root of a squared distance.
  function automatic logic [63:0] floor_root(logic [127:0] n);
    logic [63:0]  res;
    logic [63:0]  cand;
    logic [127:0] sq;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      sq = 128'(cand) * 128'(cand);
      if (sq <= n) res = cand;
    end
    return res;
  endfunction

  function automatic logic [63:0] side_len(logic signed [CoordBits-1:0] p[3],
                                           logic signed [CoordBits-1:0] q[3]);
    logic signed [127:0] d;
    logic [127:0]        s;
    s = '0;
    for (int k = 0; k < 3; k++) begin
      d = 128'(p[k]) - 128'(q[k]);
      s = s + 128'(d * d);
    end
    return floor_root(s);
  endfunction

  // Weight each vertex by its opposite side, divide by perimeter, round half away.
  function automatic center_out_t predict_incenter(tri_in_t t);
    logic signed [CoordBits-1:0] v[3][3];
    logic [63:0]                 w[3];
    logic [63:0]                 per;
    logic signed [127:0]         acc;
    logic [127:0]                m;
    logic [127:0]                q;
    logic                        neg;
    logic signed [CoordBits-1:0] c[3];
    center_out_t                 r;
    v[0] = '{t.first_x, t.first_y, t.first_z};
    v[1] = '{t.second_x, t.second_y, t.second_z};
    v[2] = '{t.third_x, t.third_y, t.third_z};
    w[0] = side_len(v[1], v[2]);
    w[1] = side_len(v[2], v[0]);
    w[2] = side_len(v[0], v[1]);
    per = w[0] + w[1] + w[2];
    r = '0;
    if (per == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    for (int k = 0; k < 3; k++) begin
      acc = '0;
      for (int i = 0; i < 3; i++) acc = acc + $signed({64'd0, w[i]}) * 128'(v[i][k]);
      neg = acc < 0;
      m = neg ? 128'(-acc) : 128'(acc);
      q = (m + (per >> 1)) / per;
      c[k] = neg ? -CoordBits'(q) : CoordBits'(q);
    end
    r.center_x = c[0];
    r.center_y = c[1];
    r.center_z = c[2];
    return r;
  endfunction

  // Compare every completed transfer with the oldest prediction.
  always @(posedge clk) begin
    center_out_t want;
    if (!rst && done) begin
      results_seen++;
      if (result.degenerate) degenerate_seen++;
      if (incenter_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", result);
      end else begin
        want = incenter_q.pop_front();
        if (result.center_x !== want.center_x || result.center_y !== want.center_y ||
            result.center_z !== want.center_z || result.degenerate !== want.degenerate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: expected x=%h y=%h z=%h deg=%b, got x=%h y=%h z=%h deg=%b",
                     want.center_x, want.center_y, want.center_z, want.degenerate,
                     result.center_x, result.center_y, result.center_z, result.degenerate);
        end
      end
    end
  end

  // Bound the run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Hold start high for one transfer; predicted value is queued at acceptance.
  task automatic send_triangle(tri_in_t t, logic check_fixed, center_out_t fixed);
    start <= 1'b1;
    operands <= t;
    do @(posedge clk); while (busy);
    incenter_q.push_back(check_fixed ? fixed : predict_incenter(t));
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    operands <= tri_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom});
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [CoordBits-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return CoordBits'($signed($urandom_range(0, 2000)) - 1000);
      1: return {1'b1, {(CoordBits-1){1'b0}}};
      2: return {1'b0, {(CoordBits-1){1'b1}}};
      default: return $urandom;
    endcase
  endfunction

  typedef struct {
    tri_in_t     t;
    logic        fixed_ok;
    center_out_t fixed;
  } stim_row_t;

  localparam logic [CoordBits-1:0] CMin = {1'b1, {(CoordBits-1){1'b0}}};
  localparam logic [CoordBits-1:0] CMax = {1'b0, {(CoordBits-1){1'b1}}};
  localparam logic [CoordBits-1:0] One  = 32'h0001_0000;

  stim_row_t table_rows[$];

  initial begin
    tri_in_t t;
    int      burst;
    logic    drained;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    operands = '0;
    mismatches = 0;
    cycles = 0;
    results_seen = 0;
    degenerate_seen = 0;
    drained = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: coincident vertices, extremes, two equal vertices, plain triangles.
    table_rows.push_back('{'0, 1'b1, '{0, 0, 0, 1'b1}});
    table_rows.push_back('{{9{CMax}}, 1'b1, '{0, 0, 0, 1'b1}});
    table_rows.push_back('{{9{CMin}}, 1'b1, '{0, 0, 0, 1'b1}});
    table_rows.push_back('{{9{32'hDEAD_BEEF}}, 1'b1, '{0, 0, 0, 1'b1}});
    table_rows.push_back('{{CMin, CMin, CMin, CMax, CMax, CMax, CMin, CMax, CMin}, 1'b0, '0});
    table_rows.push_back('{{CMax, CMax, CMax, CMin, CMin, CMin, CMax, CMin, CMax}, 1'b0, '0});
    table_rows.push_back('{{CMin, CMin, CMin, CMin, CMin, CMin, CMax, CMax, CMax}, 1'b0, '0});
    table_rows.push_back('{{One, One, One, One, One, One, 32'h0, 32'h0, 32'h0}, 1'b0, '0});
    table_rows.push_back('{{32'h0, 32'h0, 32'h0, One, 32'h0, 32'h0, 32'h0, One, 32'h0}, 1'b0, '0});
    table_rows.push_back('{{32'h0, 32'h0, 32'h0, 32'd3, 32'h0, 32'h0, 32'h0, 32'd4, 32'h0},
                          1'b0, '0});
    table_rows.push_back('{{-One, -One, -One, -One, One, 32'h0, One, 32'h0, -One}, 1'b0, '0});
    table_rows.push_back('{{32'hFFFF_FFFF, 32'h0, 32'h1, 32'h1, 32'h0, 32'hFFFF_FFFF,
                           32'h0, 32'h1, 32'h0}, 1'b0, '0});
    table_rows.push_back('{{CMax, 32'h0, 32'h0, CMin, 32'h0, 32'h0, 32'h0, CMax, 32'h0},
                          1'b0, '0});
    foreach (table_rows[i]) send_triangle(table_rows[i].t, table_rows[i].fixed_ok,
                                          table_rows[i].fixed);
    pause(2);

    // Random: bursts of triangles with gaps; some share vertices or coincide.
    for (int n = 0; n < NumRandom; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < NumRandom; b++, n++) begin
        for (int f = 0; f < 9; f++) t[f*CoordBits +: CoordBits] = rand_coord();
        case ($urandom_range(0, 9))
          0: t[3*CoordBits +: 3*CoordBits] = t[0 +: 3*CoordBits];
          1: t[6*CoordBits +: 3*CoordBits] = t[0 +: 3*CoordBits];
          2: begin
            t[3*CoordBits +: 3*CoordBits] = t[0 +: 3*CoordBits];
            t[6*CoordBits +: 3*CoordBits] = t[0 +: 3*CoordBits];
          end
          default: ;
        endcase
        send_triangle(t, 1'b0, '0);
      end
      if (!drained && n >= NumRandom / 2) begin
        // Drain the pipe completely once.
        drained = 1'b1;
        start <= 1'b0;
        while (incenter_q.size() != 0) @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        pause($urandom_range(1, 100));
      end
    end
    start <= 1'b0;

    while (incenter_q.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    $display("Covered %0d triangles, %0d results, %0d degenerate.",
             NumRandom + table_rows.size(), results_seen, degenerate_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Mismatches: %0d", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
